@@ src/sitda_pkg.sv @@
// Package for the signed integer to decimal ASCII converter: sizes, character codes, types.
package sitda_pkg;

  localparam int DIGITS = 5;
  localparam int VAL_W  = 16;
  localparam int MAG_W  = VAL_W + 1;
  localparam int CHAR_W = 8;
  localparam int NCH    = DIGITS + 1;
  localparam int NSTG   = DIGITS + 1;
  localparam int CNT_W  = $clog2(NCH + 1);
  localparam int IDX_W  = $clog2(NCH);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam int                RADIX      = 10;

  function automatic logic [63:0] pow10(input int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) begin
      p = p * 64'(RADIX);
    end
    return p;
  endfunction

  localparam logic [63:0] MAG_LIMIT = pow10(DIGITS) - 64'd1;

  typedef logic [CHAR_W-1:0] char_t;
  typedef char_t [NCH-1:0] chars_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             started;
    chars_t           chars;
    logic [CNT_W-1:0] cnt;
  } stage_t;

endpackage

@@ src/signed_int_to_decimal_ascii.sv @@
// Top level: pipelined signed 16-bit to decimal ASCII converter with character serializer.
//
// Usage:
//   Input: drive value_i and raise start_i; the value transfers at a rising edge with
//   start_i high and busy_o low. busy_o never depends on start_i.
//   Output: each character appears on char_out_o for one cycle with strobe_o high;
//   last_o marks the final character of a number. Characters of one number come in
//   consecutive cycles, minus sign first when negative, leading zeros suppressed.
//   Pipeline: stage 0 takes sign and magnitude, then one stage per decimal digit,
//   then the serializer, which registers the characters onto the ports.
//   Throughput: a number has 1 to 6 characters. The serializer emits one character
//   a cycle and sets the pace; the digit pipeline fills behind it and busy_o is high
//   while every stage holds a number and the serializer is not on a last character.
//   Reset: rst_ni low clears all valid bits and the serializer; no output follows.
//   The receiver cannot stall: each result transfers in the cycle it is shown.
module signed_int_to_decimal_ascii
  import sitda_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    strobe_o,
  output logic [CHAR_W-1:0]       char_out_o,
  output logic                    last_o
);

  stage_t          st_q [NSTG];
  stage_t          st_d [NSTG];
  logic [NSTG-1:0] v_q, v_d, en;

  logic             act_q, act_d;
  chars_t           buf_q, buf_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] lidx_q, lidx_d;
  logic             sr_take;

  // stage 0: sign, magnitude, saturation
  always_comb begin
    logic             neg;
    logic [MAG_W-1:0] mag;
    neg = value_i[VAL_W-1];
    mag = neg ? (MAG_W'(1 << VAL_W) - MAG_W'(unsigned'(value_i)))
              : MAG_W'(unsigned'(value_i));
    if (64'(mag) > MAG_LIMIT) begin
      mag = MAG_W'(MAG_LIMIT);
    end
    st_d[0].mag     = mag;
    st_d[0].started = 1'b0;
    st_d[0].chars   = '0;
    st_d[0].chars[0] = neg ? CHAR_MINUS : CHAR_ZERO;
    st_d[0].cnt     = neg ? CNT_W'(1) : CNT_W'(0);
  end

  // digit stages, most significant first
  for (genvar k = 1; k < NSTG; k++) begin : g_dig
    localparam logic [63:0] P = pow10(DIGITS - k);
    always_comb begin
      logic [3:0]       d;
      logic [MAG_W-1:0] sub;
      logic             emit;
      d   = 4'd0;
      sub = '0;
      for (int j = 1; j < RADIX; j++) begin
        if (64'(st_q[k-1].mag) >= 64'(j) * P) begin
          d   = 4'(j);
          sub = MAG_W'(64'(j) * P);
        end
      end
      emit = st_q[k-1].started || (d != 4'd0) || (k == NSTG - 1);
      st_d[k].mag     = st_q[k-1].mag - sub;
      st_d[k].started = emit;
      st_d[k].chars   = st_q[k-1].chars;
      for (int i = 0; i < NCH; i++) begin
        if (emit && (CNT_W'(i) == st_q[k-1].cnt)) begin
          st_d[k].chars[i] = CHAR_ZERO + {4'b0, d};
        end
      end
      st_d[k].cnt = st_q[k-1].cnt + CNT_W'(emit);
    end
  end

  // stall chain
  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || sr_take;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
    v_d[0] = en[0] ? start_i : v_q[0];
    for (int i = 1; i < NSTG; i++) begin
      v_d[i] = en[i] ? v_q[i-1] : v_q[i];
    end
  end

  assign busy_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // serializer
  assign last_o     = act_q && (idx_q == lidx_q);
  assign strobe_o   = act_q;
  assign char_out_o = buf_q[idx_q];
  assign sr_take    = !act_q || last_o;

  always_comb begin
    act_d  = act_q;
    buf_d  = buf_q;
    idx_d  = idx_q + IDX_W'(1);
    lidx_d = lidx_q;
    if (sr_take) begin
      act_d  = v_q[NSTG-1];
      buf_d  = st_q[NSTG-1].chars;
      idx_d  = '0;
      lidx_d = IDX_W'(st_q[NSTG-1].cnt - CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    idx_q  <= idx_d;
    lidx_q <= lidx_d;
  end

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (char_out_o == CHAR_MINUS && !last_o) ||
                 (char_out_o >= CHAR_ZERO && char_out_o <= CHAR_NINE))
    else $error("illegal character on output");

  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o)
    else $error("gap inside a number");

  a_minus_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && char_out_o == CHAR_MINUS |=> strobe_o && char_out_o != CHAR_MINUS)
    else $error("minus sign not followed by a digit");

  a_busy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> v_q[0] && act_q && !last_o)
    else $error("busy without a stalled pipeline");

endmodule

@@ verif/tb_top.sv @@
// Testbench for signed_int_to_decimal_ascii: predicts each number's decimal text and checks it.
`timescale 1ns / 100ps

module tb_top
  import sitda_pkg::*;
();

  localparam int NUM_RANDOM  = 400;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    char_t ch;
    logic  last;
  } text_char_t;

  logic                    clk_i      = 1'b0;
  logic                    rst_ni     = 1'b0;
  logic                    start_i    = 1'b0;
  logic signed [VAL_W-1:0] value_i    = '0;
  logic                    busy_o;
  logic                    strobe_o;
  logic [CHAR_W-1:0]       char_out_o;
  logic                    last_o;

  logic signed [VAL_W-1:0] numbers_to_send[$];
  text_char_t              expected_text[$];
  int                      total_numbers = 0;
  int                      numbers_sent  = 0;
  int                      error_count   = 0;
  int                      stall_cycles  = 0;
  logic                    timed_out     = 1'b0;

  signed_int_to_decimal_ascii dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .value_i    (value_i),
    .strobe_o   (strobe_o),
    .char_out_o (char_out_o),
    .last_o     (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Append the decimal text of one number to the expected characters.
  function automatic void spell_decimal(input logic signed [VAL_W-1:0] number);
    int         mag;
    int         divisor;
    int         digit;
    bit         started;
    text_char_t tc;
    mag     = (number < 0) ? -int'(number) : int'(number);
    divisor = 1;
    started = 0;
    for (int k = 1; k < DIGITS; k++) divisor *= RADIX;
    if (mag > divisor * RADIX - 1) mag = divisor * RADIX - 1;
    tc.last = 1'b0;
    if (number < 0) begin
      tc.ch = CHAR_MINUS;
      expected_text.push_back(tc);
    end
    while (divisor > 0) begin
      digit = mag / divisor;
      if (digit != 0 || started) begin
        tc.ch = CHAR_ZERO + char_t'(digit);
        expected_text.push_back(tc);
        mag -= digit * divisor;
        started = 1;
      end
      divisor /= RADIX;
    end
    if (!started) begin
      tc.ch = CHAR_ZERO;
      expected_text.push_back(tc);
    end
    expected_text[$].last = 1'b1;
  endfunction

  // Driver: one number per transfer, random gaps except for a long burst.
  always @(posedge clk_i) begin : drive_numbers
    logic transfer;
    logic gap;
    if (rst_ni) begin
      transfer = start_i && !busy_o;
      gap      = !(numbers_sent >= 150 && numbers_sent < 260) && ($urandom_range(99) < 33);
      if (transfer) begin
        spell_decimal(value_i);
        numbers_sent++;
      end
      if (!start_i || transfer) begin
        if (numbers_to_send.size() > 0 && !gap) begin
          value_i <= numbers_to_send.pop_front();
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed character is checked against the oldest expectation.
  always @(posedge clk_i) begin : check_text
    text_char_t want;
    if (rst_ni && strobe_o) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual char %h last %b",
                 $time, char_out_o, last_o);
        error_count++;
      end else begin
        want = expected_text.pop_front();
        if (char_out_o !== want.ch) begin
          $display("%0t: char_out mismatch: expected %h, actual %h",
                   $time, want.ch, char_out_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, last_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: cycles in which no transfer happens on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || strobe_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) timed_out <= 1'b1;
    end
  end

  initial begin : stimulus
    int                      n_digits;
    int                      lo;
    int                      hi;
    int                      mag;
    logic signed [VAL_W-1:0] v;
    logic signed [VAL_W-1:0] directed[$];

    directed = '{16'sd0, 16'sd1, -16'sd1, 16'sd9, -16'sd9, 16'sd10, -16'sd10, 16'sd99,
                 16'sd100, 16'sd999, 16'sd1000, 16'sd9999, 16'sd10000, -16'sd10000,
                 16'sd32767, -16'sd32768, -16'sd32767, 16'sd12345, 16'sd10005,
                 -16'sd20030, 16'sd24464, -16'sd99, 16'sd5};
    foreach (directed[i]) numbers_to_send.push_back(directed[i]);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if ($urandom_range(99) < 40) begin
        v = VAL_W'($urandom());
      end else begin
        n_digits = $urandom_range(1, DIGITS);
        lo       = (n_digits == 1) ? 0 : 1;
        for (int k = 1; k < n_digits; k++) lo *= RADIX;
        hi       = (n_digits == 1) ? 9 : lo * RADIX - 1;
        if ($urandom_range(1)) begin
          if (hi > 32768) hi = 32768;
          mag = $urandom_range(lo, hi);
          v   = VAL_W'(-mag);
        end else begin
          if (hi > 32767) hi = 32767;
          mag = $urandom_range(lo, hi);
          v   = VAL_W'(mag);
        end
      end
      numbers_to_send.push_back(v);
    end
    total_numbers = numbers_to_send.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (numbers_sent < total_numbers && !timed_out) @(posedge clk_i);
    while (expected_text.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (DIGITS + 6) @(posedge clk_i);

    if (!timed_out && error_count == 0 && expected_text.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/sitda_pkg.sv
src/signed_int_to_decimal_ascii.sv
verif/tb_top.sv
